### rtl/core/assert_macros.svh
// ----------------------------------------------------------------------------
// assert_macros.svh
// Assertion macros used by the sliding median time budget RTL.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is low.
`define ASSERT_IMP(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");

// Next-cycle implication, disabled while reset is low.
`define ASSERT_NXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

### rtl/core/smtb_pkg.sv
// ----------------------------------------------------------------------------
// smtb_pkg
// Widths, reset values, register indexes and cell control type.
// ----------------------------------------------------------------------------
package smtb_pkg;

    localparam int VAL_W      = 15;
    localparam int LIM_W      = 16;
    localparam int TIME_W     = 32;
    localparam int WINDOW_DEF = 20;
    localparam int ADDR_W     = 4;
    localparam int DATA_W     = 32;

    localparam logic [VAL_W-1:0] CAP_RESET   = 15'd1000;
    localparam logic [VAL_W-1:0] BLOW_RESET  = 15'd20;
    localparam logic [VAL_W-1:0] MID_RESET   = 15'd33;
    localparam logic [VAL_W-1:0] FLOOR_RESET = 15'd36;

    typedef enum logic [1:0] {
        REG_SAMPLE_CAP  = 2'd0,
        REG_BUDGET_LOW  = 2'd1,
        REG_MID_LEVEL   = 2'd2,
        REG_LIMIT_FLOOR = 2'd3
    } t_reg_idx;

    typedef struct packed {
        logic             load;
        logic             sort;
        logic             phase;
        logic [VAL_W-1:0] sample;
    } t_cell_ctrl;

endpackage

### rtl/core/smtb_cell.sv
// ----------------------------------------------------------------------------
// smtb_cell
// One rank position: holds a sample and its slot tag, compare-exchanges
// with a neighbor on alternating phases.
// ----------------------------------------------------------------------------
module smtb_cell import smtb_pkg::*; #(
    parameter int IDX    = 0,
    parameter int WINDOW = WINDOW_DEF,
    parameter int SLOT_W = $clog2(WINDOW)
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  t_cell_ctrl        i_ctrl,
    input  logic [SLOT_W-1:0] i_slot,
    input  logic [VAL_W-1:0]  i_left_val,
    input  logic [SLOT_W-1:0] i_left_slot,
    input  logic [VAL_W-1:0]  i_right_val,
    input  logic [SLOT_W-1:0] i_right_slot,
    output logic [VAL_W-1:0]  o_val,
    output logic [SLOT_W-1:0] o_slot
);

    localparam bit MY_PAR = bit'(IDX % 2);
    localparam bit HAS_R  = (IDX < WINDOW - 1);
    localparam bit HAS_L  = (IDX > 0);

    logic [VAL_W-1:0]  r_val, n_val;
    logic [SLOT_W-1:0] r_slot, n_slot;

    always_comb begin
        n_val  = r_val;
        n_slot = r_slot;
        if (i_ctrl.load && (r_slot == i_slot)) begin
            n_val = i_ctrl.sample;
        end else if (i_ctrl.sort) begin
            if (HAS_R && (i_ctrl.phase == MY_PAR) && (r_val > i_right_val)) begin
                n_val  = i_right_val;
                n_slot = i_right_slot;
            end else if (HAS_L && (i_ctrl.phase != MY_PAR) && (i_left_val > r_val)) begin
                n_val  = i_left_val;
                n_slot = i_left_slot;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_val  <= FLOOR_RESET;
            r_slot <= SLOT_W'(IDX);
        end else begin
            r_val  <= n_val;
            r_slot <= n_slot;
        end
    end

    assign o_val  = r_val;
    assign o_slot = r_slot;

endmodule

### rtl/core/smtb_limit.sv
// ----------------------------------------------------------------------------
// smtb_limit
// Budget and limit arithmetic with the result payload register.
// ----------------------------------------------------------------------------
module smtb_limit import smtb_pkg::*; (
    input  logic             i_clk,
    input  logic             i_load,
    input  logic [VAL_W-1:0] i_sample,
    input  logic [VAL_W-1:0] i_median,
    input  logic [VAL_W-1:0] i_budget_low,
    input  logic [VAL_W-1:0] i_mid_level,
    input  logic [VAL_W-1:0] i_limit_floor,
    output logic [LIM_W-1:0] o_time_limit,
    output logic [VAL_W-1:0] o_median
);

    logic [VAL_W+1:0] w_x3;
    logic [LIM_W-1:0] w_half;
    logic [LIM_W-1:0] w_lo;
    logic [VAL_W-1:0] w_budget;
    logic [LIM_W-1:0] w_sum;
    logic [LIM_W-1:0] w_upper;
    logic [LIM_W-1:0] w_capped;
    logic [LIM_W-1:0] w_limit;
    logic [LIM_W-1:0] r_time_limit;
    logic [VAL_W-1:0] r_median;

    always_comb begin
        w_x3   = {2'b00, i_sample} + {1'b0, i_sample, 1'b0};
        w_half = w_x3[VAL_W+1:1];
        w_lo   = (w_half < {1'b0, i_budget_low}) ? {1'b0, i_budget_low} : w_half;
        w_budget = (w_lo > {1'b0, i_mid_level}) ? i_mid_level : w_lo[VAL_W-1:0];
        w_sum  = {1'b0, w_budget} + {1'b0, i_median};
        if (i_sample >= i_mid_level) begin
            w_upper = {i_sample, 1'b0};
        end else begin
            w_upper = {1'b0, i_sample} + {1'b0, i_mid_level};
        end
        w_capped = (w_sum > w_upper) ? w_upper : w_sum;
        w_limit  = (w_capped < {1'b0, i_limit_floor}) ? {1'b0, i_limit_floor} : w_capped;
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_time_limit <= w_limit;
            r_median     <= i_median;
        end
    end

    assign o_time_limit = r_time_limit;
    assign o_median     = r_median;

endmodule

### rtl/core/sliding_median_time_budget_top.sv
// ----------------------------------------------------------------------------
// sliding_median_time_budget_top
// Sliding-window running median of elapsed time and derived time budget.
// ----------------------------------------------------------------------------
// Each input transaction (now_time, mark_time) gives one output transaction
// (time_limit, median_sample): the difference is registered, then saturated
// as it overwrites the oldest cell, then WINDOW odd-even transposition passes
// run over the row of rank cells, and the limit arithmetic is registered
// once the output is free. One transaction is in flight at a time; a new one
// is taken while the previous result waits on the output. The window holds
// limit_floor's reset value only after reset; later writes of limit_floor do
// not refill it.
module sliding_median_time_budget_top import smtb_pkg::*; #(
    parameter int WINDOW = WINDOW_DEF
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    // APB configuration
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [ADDR_W-1:0] paddr,
    input  logic [DATA_W-1:0] pwdata,
    output logic [DATA_W-1:0] prdata,
    output logic              pready,
    // input stream
    input  logic              s_axis_tvalid,
    output logic              s_axis_tready,
    input  logic [63:0]       s_axis_tdata,  // [31:0] now_time, [63:32] mark_time
    // output stream
    output logic              m_axis_tvalid,
    input  logic              m_axis_tready,
    output logic [31:0]       m_axis_tdata   // [15:0] time_limit, [30:16] median_sample
);

    localparam int SLOT_W = $clog2(WINDOW);
    localparam int MED    = WINDOW / 2;

    typedef enum logic [1:0] {
        S_IDLE,
        S_INS,
        S_SORT,
        S_CALC
    } t_state;

    t_state              r_state;
    logic [VAL_W-1:0]    r_cap, r_blow, r_mid, r_floor;
    logic [TIME_W-1:0]   r_diff;
    logic [VAL_W-1:0]    r_sample;
    logic [VAL_W-1:0]    n_sample;
    logic [SLOT_W-1:0]   r_oldest;
    logic [SLOT_W-1:0]   r_cnt;
    logic                r_out_valid;
    logic                w_in_acc;
    logic                w_out_free;
    logic                w_res_load;
    logic                w_cfg_wr;
    t_reg_idx            w_idx;
    t_cell_ctrl          w_ctrl;
    logic [VAL_W-1:0]    w_val  [WINDOW];
    logic [SLOT_W-1:0]   w_slot [WINDOW];
    logic [LIM_W-1:0]    w_time_limit;
    logic [VAL_W-1:0]    w_median;

    // configuration
    assign pready   = 1'b1;
    assign w_idx    = t_reg_idx'(paddr[3:2]);
    assign w_cfg_wr = psel && penable && pwrite && pready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cap   <= CAP_RESET;
            r_blow  <= BLOW_RESET;
            r_mid   <= MID_RESET;
            r_floor <= FLOOR_RESET;
        end else if (w_cfg_wr) begin
            unique case (w_idx)
                REG_SAMPLE_CAP:  r_cap   <= pwdata[VAL_W-1:0];
                REG_BUDGET_LOW:  r_blow  <= pwdata[VAL_W-1:0];
                REG_MID_LEVEL:   r_mid   <= pwdata[VAL_W-1:0];
                REG_LIMIT_FLOOR: r_floor <= pwdata[VAL_W-1:0];
            endcase
        end
    end

    always_comb begin
        unique case (w_idx)
            REG_SAMPLE_CAP:  prdata = {{(DATA_W-VAL_W){1'b0}}, r_cap};
            REG_BUDGET_LOW:  prdata = {{(DATA_W-VAL_W){1'b0}}, r_blow};
            REG_MID_LEVEL:   prdata = {{(DATA_W-VAL_W){1'b0}}, r_mid};
            REG_LIMIT_FLOOR: prdata = {{(DATA_W-VAL_W){1'b0}}, r_floor};
        endcase
    end

    // control
    assign s_axis_tready = (r_state == S_IDLE);
    assign w_in_acc      = s_axis_tvalid && s_axis_tready;
    assign w_out_free    = !r_out_valid || m_axis_tready;
    assign w_res_load    = (r_state == S_CALC) && w_out_free;
    assign n_sample      = (r_diff > {{(TIME_W-VAL_W){1'b0}}, r_cap}) ? r_cap
                                                                     : r_diff[VAL_W-1:0];

    always_comb begin
        w_ctrl.load   = (r_state == S_INS);
        w_ctrl.sort   = (r_state == S_SORT);
        w_ctrl.phase  = r_cnt[0];
        w_ctrl.sample = n_sample;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_oldest    <= '0;
            r_cnt       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (w_res_load) begin
                r_out_valid <= 1'b1;
            end else if (r_out_valid && m_axis_tready) begin
                r_out_valid <= 1'b0;
            end
            unique case (r_state)
                S_IDLE: begin
                    if (w_in_acc) begin
                        r_diff  <= s_axis_tdata[31:0] - s_axis_tdata[63:32];
                        r_state <= S_INS;
                    end
                end
                S_INS: begin
                    r_sample <= n_sample;
                    r_oldest <= (r_oldest == SLOT_W'(WINDOW - 1)) ? '0 : r_oldest + 1'b1;
                    r_cnt    <= '0;
                    r_state  <= S_SORT;
                end
                S_SORT: begin
                    r_cnt <= r_cnt + 1'b1;
                    if (r_cnt == SLOT_W'(WINDOW - 1)) begin
                        r_state <= S_CALC;
                    end
                end
                S_CALC: begin
                    if (w_out_free) begin
                        r_state <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    // rank cells
    for (genvar g = 0; g < WINDOW; g++) begin : g_cell
        logic [VAL_W-1:0]  w_lv, w_rv;
        logic [SLOT_W-1:0] w_ls, w_rs;
        if (g == 0) begin : g_lend
            assign w_lv = '0;
            assign w_ls = '0;
        end else begin : g_lnb
            assign w_lv = w_val[g-1];
            assign w_ls = w_slot[g-1];
        end
        if (g == WINDOW - 1) begin : g_rend
            assign w_rv = '1;
            assign w_rs = '0;
        end else begin : g_rnb
            assign w_rv = w_val[g+1];
            assign w_rs = w_slot[g+1];
        end
        smtb_cell #(
            .IDX    (g),
            .WINDOW (WINDOW),
            .SLOT_W (SLOT_W)
        ) u_cell (
            .i_clk        (i_clk),
            .i_rst_n      (i_rst_n),
            .i_ctrl       (w_ctrl),
            .i_slot       (r_oldest),
            .i_left_val   (w_lv),
            .i_left_slot  (w_ls),
            .i_right_val  (w_rv),
            .i_right_slot (w_rs),
            .o_val        (w_val[g]),
            .o_slot       (w_slot[g])
        );
    end

    smtb_limit u_limit (
        .i_clk         (i_clk),
        .i_load        (w_res_load),
        .i_sample      (r_sample),
        .i_median      (w_val[MED]),
        .i_budget_low  (r_blow),
        .i_mid_level   (r_mid),
        .i_limit_floor (r_floor),
        .o_time_limit  (w_time_limit),
        .o_median      (w_median)
    );

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {1'b0, w_median, w_time_limit};

    // assertions
`include "assert_macros.svh"

    `ASSERT_NXT(a_acc_to_ins, i_clk, i_rst_n, w_in_acc, r_state == S_INS)
    `ASSERT_IMP(a_median_sorted, i_clk, i_rst_n, r_state == S_CALC, w_val[MED-1] <= w_val[MED])
    `ASSERT_IMP(a_oldest_range, i_clk, i_rst_n, 1'b1, r_oldest <= SLOT_W'(WINDOW - 1))
    `ASSERT_NXT(a_calc_valid, i_clk, i_rst_n, w_res_load, r_out_valid)

endmodule
